>>> hdl/rsf_pkg.sv
// Shared types, widths and constants of the radix seven-segment formatter.
// No dependencies; every other file of the block imports this package.
package rsf_pkg;

  // Field widths of the input and result items.
  localparam int VALUE_W   = 16;
  localparam int RADIX_W   = 5;
  localparam int DOT_W     = 4;
  localparam int POSN_W    = 2;
  localparam int SEG_W     = 8;
  localparam int DIGIT_W   = 4;

  // Default display size, handed to the top level as a parameter.
  localparam int DIGIT_COUNT_DEF = 4;

  // Conversion consumes this many value bits per cycle.
  localparam int BITS_PER_STEP = 4;
  localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
  localparam int STEP_W        = $clog2(CONV_STEPS + 1);

  // Radix handling.
  localparam logic [RADIX_W-1:0] RADIX_ZERO = 5'd0;
  localparam logic [RADIX_W-1:0] RADIX_TEN  = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MAX  = 5'd16;

  // Special segment patterns.
  localparam logic [SEG_W-1:0] SEG_MINUS = 8'h40;
  localparam logic [SEG_W-1:0] SEG_DOT   = 8'h80;
  localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [SEG_W-1:0]   seg_t;

  // Hexadecimal digit glyphs.
  localparam seg_t SEG_TABLE [16] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
  };

  // Per-item flags that travel from the converter to the emitter.
  typedef struct packed {
    logic             neg;
    logic             radix_ten;
    logic             overflow;
    logic [DOT_W-1:0] dots;
  } rsf_flags_t;

endpackage

>>> hdl/rsf_channels.sv
// Valid/ready channel interfaces for the formatter's input and result items.
// Depends on rsf_pkg for the field widths.
interface rsf_in_if;
  import rsf_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               signed_mode;
  logic [RADIX_W-1:0] radix_code;
  logic [DOT_W-1:0]   dot_mask;

  modport source (output valid, output value, output signed_mode, output radix_code,
                  output dot_mask, input ready);
  modport sink   (input valid, input value, input signed_mode, input radix_code,
                  input dot_mask, output ready);
endinterface

interface rsf_out_if;
  import rsf_pkg::*;

  logic              valid;
  logic              ready;
  logic [POSN_W-1:0] position;
  logic [SEG_W-1:0]  segments;
  logic              last;

  modport source (output valid, output position, output segments, output last,
                  input ready);
  modport sink   (input valid, input position, input segments, input last,
                  output ready);
endinterface

>>> hdl/rsf_digit_cell.sv
// One digit cell of the radix conversion chain: doubles its digit and adds
// the incoming bit, folding back by the radix. Depends on rsf_pkg.
module rsf_digit_cell (
  input  logic                                clk,
  input  logic                                clear,
  input  logic                                enable,
  input  logic [rsf_pkg::RADIX_W-1:0]         radix,
  input  logic [rsf_pkg::BITS_PER_STEP-1:0]   carry_in,
  output logic [rsf_pkg::BITS_PER_STEP-1:0]   carry_out,
  output rsf_pkg::digit_t                     digit
);
  import rsf_pkg::*;

  digit_t digit_r;
  digit_t digit_nxt;

  // Shift the bits in most significant first; each step keeps the digit
  // below the radix and passes the overflow bit to the next cell.
  always_comb begin
    logic [DIGIT_W:0] acc;
    acc       = '0;
    digit_nxt = digit_r;
    carry_out = '0;
    for (int k = BITS_PER_STEP - 1; k >= 0; k--) begin
      acc = {digit_nxt, carry_in[k]};
      if (acc >= (DIGIT_W + 1)'(radix)) begin
        acc          = acc - (DIGIT_W + 1)'(radix);
        carry_out[k] = 1'b1;
      end
      digit_nxt = acc[DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      digit_r <= '0;
    end else if (enable) begin
      digit_r <= digit_nxt;
    end
  end

  assign digit = digit_r;

endmodule

>>> hdl/rsf_converter.sv
// Input stage and conversion chain: takes an item, forms the magnitude and
// feeds it through a row of digit cells. Depends on rsf_pkg, rsf_digit_cell.
module rsf_converter #(
  parameter int DIGIT_COUNT = rsf_pkg::DIGIT_COUNT_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  rsf_in_if.sink                                        in_ch,
  output logic                                          done_valid,
  input  logic                                          done_ready,
  output logic [DIGIT_COUNT-1:0][rsf_pkg::DIGIT_W-1:0]  done_digits,
  output rsf_pkg::rsf_flags_t                           done_flags
);
  import rsf_pkg::*;

  logic                busy_r, busy_nxt;
  logic [STEP_W-1:0]   step_r;
  logic [VALUE_W-1:0]  shift_r;
  logic [RADIX_W-1:0]  radix_r;
  logic                neg_r;
  logic [DOT_W-1:0]    dots_r;
  logic                ovf_r;

  logic                accept;
  logic                running;
  logic [RADIX_W-1:0]  radix_eff;
  logic [VALUE_W-1:0]  magnitude;
  logic                in_neg;

  logic [DIGIT_COUNT:0][BITS_PER_STEP-1:0] carry;

  // Conversion runs a fixed number of steps; the result then waits here.
  assign running    = busy_r && (step_r != STEP_W'(CONV_STEPS));
  assign done_valid = busy_r && (step_r == STEP_W'(CONV_STEPS));
  assign in_ch.ready = !busy_r || (done_valid && done_ready);
  assign accept     = in_ch.valid && in_ch.ready;

  // Radix zero means ten; anything above sixteen is held at sixteen.
  always_comb begin
    if (in_ch.radix_code == RADIX_ZERO) begin
      radix_eff = RADIX_TEN;
    end else if (in_ch.radix_code > RADIX_MAX) begin
      radix_eff = RADIX_MAX;
    end else begin
      radix_eff = in_ch.radix_code;
    end
  end

  // Negative signed numbers are shown by magnitude; the most negative
  // value wraps to itself, which reads correctly as unsigned.
  assign in_neg    = in_ch.signed_mode && in_ch.value[VALUE_W-1];
  assign magnitude = in_neg ? (~in_ch.value + VALUE_W'(1)) : in_ch.value;

  // Control state.
  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (done_valid && done_ready) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  // Item registers and step counter.
  always_ff @(posedge clk) begin
    if (accept) begin
      step_r  <= '0;
      shift_r <= magnitude;
      radix_r <= radix_eff;
      neg_r   <= in_neg;
      dots_r  <= in_ch.dot_mask;
      ovf_r   <= 1'b0;
    end else if (running) begin
      step_r  <= step_r + STEP_W'(1);
      shift_r <= shift_r << BITS_PER_STEP;
      ovf_r   <= ovf_r || (|carry[DIGIT_COUNT]);
    end
  end

  // The least significant cell takes the top bits of the magnitude.
  assign carry[0] = shift_r[VALUE_W-1 -: BITS_PER_STEP];

  for (genvar g = 0; g < DIGIT_COUNT; g++) begin : g_cell
    rsf_digit_cell u_cell (
      .clk       (clk),
      .clear     (accept),
      .enable    (running),
      .radix     (radix_r),
      .carry_in  (carry[g]),
      .carry_out (carry[g+1]),
      .digit     (done_digits[g])
    );
  end

  // Flags handed to the emitter with the digits.
  always_comb begin
    done_flags.neg       = neg_r;
    done_flags.radix_ten = (radix_r == RADIX_TEN);
    done_flags.overflow  = ovf_r;
    done_flags.dots      = dots_r;
  end

endmodule

>>> hdl/rsf_emitter.sv
// Output stage: holds one converted item and sends its display writes,
// rightmost digit first, then the minus sign. Depends on rsf_pkg.
module rsf_emitter #(
  parameter int DIGIT_COUNT = rsf_pkg::DIGIT_COUNT_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          ld_valid,
  output logic                                          ld_ready,
  input  logic [DIGIT_COUNT-1:0][rsf_pkg::DIGIT_W-1:0]  ld_digits,
  input  rsf_pkg::rsf_flags_t                           ld_flags,
  rsf_out_if.source                                     out_ch
);
  import rsf_pkg::*;

  localparam int CNT_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  logic                                 valid_r, valid_nxt;
  logic                                 minus_r, minus_nxt;
  logic [CNT_W-1:0]                     pos_r;
  logic                                 first_r;
  logic [DIGIT_COUNT-1:0][DIGIT_W-1:0]  dig_r;
  rsf_flags_t                           flags_r;

  logic             take;
  logic             load;
  logic             pos_zero;
  logic             blank;
  logic [CNT_W+1:0] pos_ext;

  assign take     = out_ch.valid && out_ch.ready;
  assign pos_zero = (pos_r == '0);
  assign ld_ready = !valid_r || (out_ch.ready && out_ch.last);
  assign load     = ld_valid && ld_ready;

  // Radix ten blanks a position once the rest of the number is zero.
  assign blank = flags_r.radix_ten && !first_r && !flags_r.overflow && !(|dig_r);

  // Result item from the held digit row.
  assign pos_ext         = {2'b00, pos_r};
  assign out_ch.valid    = valid_r;
  assign out_ch.last     = minus_r || (pos_zero && !flags_r.neg);
  assign out_ch.position = minus_r ? POSN_W'(0) : pos_ext[POSN_W-1:0];

  always_comb begin
    if (minus_r) begin
      out_ch.segments = SEG_MINUS;
    end else if (blank) begin
      out_ch.segments = SEG_BLANK;
    end else begin
      out_ch.segments = SEG_TABLE[dig_r[0]] | (flags_r.dots[0] ? SEG_DOT : SEG_BLANK);
    end
  end

  // Control state: digit writes, then the optional minus sign.
  always_comb begin
    valid_nxt = valid_r;
    minus_nxt = minus_r;
    if (load) begin
      valid_nxt = 1'b1;
      minus_nxt = 1'b0;
    end else if (take) begin
      if (minus_r) begin
        valid_nxt = 1'b0;
      end else if (pos_zero) begin
        if (flags_r.neg) begin
          minus_nxt = 1'b1;
        end else begin
          valid_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      minus_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      minus_r <= minus_nxt;
    end
  end

  // Digit row shifts one place toward the output per write.
  always_ff @(posedge clk) begin
    if (load) begin
      dig_r   <= ld_digits;
      flags_r <= ld_flags;
      pos_r   <= CNT_W'(DIGIT_COUNT - 1);
      first_r <= 1'b1;
    end else if (take && !minus_r && !pos_zero) begin
      dig_r        <= dig_r >> DIGIT_W;
      flags_r.dots <= flags_r.dots >> 1;
      pos_r        <= pos_r - CNT_W'(1);
      first_r      <= 1'b0;
    end
  end

endmodule

>>> hdl/radix_seven_segment_formatter.sv
// Top level of the radix seven-segment formatter.
// Depends on rsf_pkg, rsf_channels, rsf_converter and rsf_emitter.
//
// Usage:
//   in_ch carries one number per item: value, signed_mode, radix_code and
//   dot_mask. out_ch carries display writes (position, segments, last),
//   one per cycle while out_ch.ready is high: DIGIT_COUNT digit writes from
//   the rightmost position leftward, plus a minus-sign write to position 0 for
//   negative numbers. last marks the final write of each item.
// Timing: an accepted item is converted in the conversion chain of digit
//   cells, which takes 4 value bits per cycle, and is then loaded into the
//   emitter register, from which its first write is offered.
// Throughput: the conversion chain and the emitter register overlap, so a new
//   item is taken while the previous one's writes are still being sent.
// Reset: rst_n low clears both stages; nothing is in flight afterward.
// Stall: when out_ch.ready is low the current write holds, the finished
//   conversion waits in the chain, and in_ch.ready drops until room opens.
module radix_seven_segment_formatter #(
  parameter int DIGIT_COUNT = rsf_pkg::DIGIT_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rsf_in_if.sink     in_ch,
  rsf_out_if.source  out_ch
);
  import rsf_pkg::*;

  logic                                conv_valid;
  logic                                conv_ready;
  logic [DIGIT_COUNT-1:0][DIGIT_W-1:0] conv_digits;
  rsf_flags_t                          conv_flags;

  // Conversion chain.
  rsf_converter #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_converter (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .done_valid  (conv_valid),
    .done_ready  (conv_ready),
    .done_digits (conv_digits),
    .done_flags  (conv_flags)
  );

  // Write sequencer.
  rsf_emitter #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_emitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld_valid  (conv_valid),
    .ld_ready  (conv_ready),
    .ld_digits (conv_digits),
    .ld_flags  (conv_flags),
    .out_ch    (out_ch)
  );

endmodule

>>> sim/testbench.sv
// Testbench for the radix seven-segment formatter: directed and random numbers in,
// display writes checked against a built-in predictor. Depends on rsf_pkg,
// rsf_channels and the formatter RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rsf_pkg::*;

  localparam int DIGITS       = DIGIT_COUNT_DEF;
  localparam int RANDOM_ITEMS = 296;
  localparam int HOLD_CYCLES  = 150;
  localparam int SETTLE_CYCLES = 20;
  localparam int LIMIT_NS     = 2_000_000;

  // One number to display, as it travels on the input channel.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               signed_mode;
    logic [RADIX_W-1:0] radix_code;
    logic [DOT_W-1:0]   dot_mask;
  } number_t;

  // One display register write.
  typedef struct packed {
    logic [POSN_W-1:0] position;
    seg_t              segments;
    logic              last;
  } disp_write_t;

  // A directed row. When write_count is nonzero, the segment bytes of the
  // writes are given here, first write in the top byte; positions follow
  // the fixed order (rightmost leftward, then the minus sign on position 0).
  typedef struct packed {
    number_t     num;
    logic [2:0]  write_count;
    logic [39:0] seg_bytes;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 24;

  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    // Zero in decimal: rightmost digit only, the rest blanked.
    '{'{16'h0000, 1'b0, RADIX_ZERO, 4'h0}, 3'd4, 40'h3F_00_00_00_00},
    // All ones in hex with every dot lit.
    '{'{16'hFFFF, 1'b0, RADIX_MAX,  4'hF}, 3'd4, 40'hF1_F1_F1_F1_00},
    // Minus one in decimal: magnitude 1 and a minus sign.
    '{'{16'hFFFF, 1'b1, RADIX_TEN,  4'h0}, 3'd5, 40'h06_00_00_00_40},
    // Most negative value in hex: magnitude 0x8000.
    '{'{16'h8000, 1'b1, RADIX_MAX,  4'h0}, 3'd5, 40'h3F_3F_3F_7F_40},
    // Radix code above sixteen saturates to hex.
    '{'{16'h1234, 1'b0, 5'd31,      4'h0}, 3'd4, 40'h66_4F_5B_06_00},
    // Radix one: every digit is zero and nothing is blanked.
    '{'{16'h0005, 1'b0, 5'd1,       4'hF}, 3'd4, 40'hBF_BF_BF_BF_00},
    // Blanked positions drop their dots.
    '{'{16'h0000, 1'b0, RADIX_TEN,  4'hF}, 3'd4, 40'hBF_00_00_00_00},
    // Largest positive signed value in hex.
    '{'{16'h7FFF, 1'b1, RADIX_MAX,  4'h0}, 3'd4, 40'h71_71_71_07_00},
    // The rest goes through the predictor.
    '{'{16'd9999, 1'b0, RADIX_TEN,  4'h5}, 3'd0, 40'h0},
    '{'{16'hFFFF, 1'b0, RADIX_TEN,  4'h0}, 3'd0, 40'h0},
    '{'{16'hFB2E, 1'b1, RADIX_TEN,  4'hF}, 3'd0, 40'h0},
    '{'{16'h8000, 1'b1, RADIX_ZERO, 4'h3}, 3'd0, 40'h0},
    '{'{16'd100,  1'b0, RADIX_TEN,  4'hF}, 3'd0, 40'h0},
    '{'{16'hFFF6, 1'b1, 5'd2,       4'hA}, 3'd0, 40'h0},
    '{'{16'hABCD, 1'b0, 5'd3,       4'h6}, 3'd0, 40'h0},
    '{'{16'h4321, 1'b0, 5'd5,       4'h9}, 3'd0, 40'h0},
    '{'{16'hC0DE, 1'b1, 5'd7,       4'h0}, 3'd0, 40'h0},
    '{'{16'h0777, 1'b0, 5'd8,       4'hC}, 3'd0, 40'h0},
    '{'{16'h9999, 1'b0, 5'd9,       4'h1}, 3'd0, 40'h0},
    '{'{16'h5A5A, 1'b0, 5'd11,      4'h2}, 3'd0, 40'h0},
    '{'{16'hA5A5, 1'b1, 5'd12,      4'h4}, 3'd0, 40'h0},
    '{'{16'h00FF, 1'b0, 5'd13,      4'h8}, 3'd0, 40'h0},
    '{'{16'hF00F, 1'b0, 5'd14,      4'hF}, 3'd0, 40'h0},
    '{'{16'h3C3C, 1'b1, 5'd15,      4'h7}, 3'd0, 40'h0}
  };

  logic clk = 1'b0;
  logic rst_n;

  rsf_in_if  in_ch ();
  rsf_out_if out_ch ();

  radix_seven_segment_formatter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Writes that the accepted numbers still owe, oldest first.
  disp_write_t pending_writes [$];
  int          mismatch_count = 0;
  bit          calm = 1'b0;
  int          hold_left = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Works out the display writes of one number and queues them.
  function automatic void predict_writes(input number_t num);
    logic [16:0]      magnitude;
    int unsigned      base;
    logic [DOT_W-1:0] dots;
    logic             negative;
    int               total;
    int               k;
    disp_write_t      w;

    base = 32'(num.radix_code);
    if (base == 0) base = 10;
    if (base > 16) base = 16;
    negative  = num.signed_mode && num.value[VALUE_W-1];
    magnitude = negative ? 17'h10000 - {1'b0, num.value} : {1'b0, num.value};
    dots      = num.dot_mask;
    total     = negative ? DIGITS + 1 : DIGITS;

    for (k = 0; k < DIGITS; k++) begin
      w.position = POSN_W'(DIGITS - 1 - k);
      // Leading zeros vanish in decimal only, and take their dots with them.
      if (magnitude == 0 && base == 10 && k != 0) begin
        w.segments = SEG_BLANK;
      end else begin
        w.segments = SEG_TABLE[(magnitude % base) & 32'hF];
        if (dots[0]) w.segments = w.segments | SEG_DOT;
      end
      w.last = (k == total - 1);
      pending_writes.push_back(w);
      magnitude = 17'(magnitude / base);
      dots = dots >> 1;
    end

    // Minus sign overwrites the leftmost position.
    if (negative) begin
      w.position = '0;
      w.segments = SEG_MINUS;
      w.last     = 1'b1;
      pending_writes.push_back(w);
    end
  endfunction

  // Queues the hand-written writes of a directed row.
  function automatic void queue_written_out(input directed_row_t row);
    int          k;
    disp_write_t w;
    for (k = 0; k < row.write_count; k++) begin
      w.position = (k < DIGITS) ? POSN_W'(DIGITS - 1 - k) : '0;
      w.segments = row.seg_bytes[39 - 8*k -: 8];
      w.last     = (k == row.write_count - 1);
      pending_writes.push_back(w);
    end
  endfunction

  // Random number, biased toward small values, small negatives and the
  // usable radix codes.
  function automatic number_t random_number();
    number_t num;
    case ($urandom_range(0, 3))
      0: num.value = VALUE_W'($urandom);
      1: num.value = VALUE_W'($urandom_range(0, 20));
      2: num.value = VALUE_W'($urandom_range(0, 9999));
      default: num.value = 16'hFFFF - VALUE_W'($urandom_range(0, 300));
    endcase
    num.signed_mode = 1'($urandom);
    num.radix_code  = ($urandom_range(0, 9) < 8) ? RADIX_W'($urandom_range(0, 16))
                                                  : RADIX_W'($urandom_range(17, 31));
    num.dot_mask    = DOT_W'($urandom);
    return num;
  endfunction

  // Offers one number and returns at the edge where it is taken.
  task automatic offer_number(input number_t num);
    int gap;
    gap = calm ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.value       <= num.value;
    in_ch.signed_mode <= num.signed_mode;
    in_ch.radix_code  <= num.radix_code;
    in_ch.dot_mask    <= num.dot_mask;
    in_ch.valid       <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drops the input and waits until every queued write has come out.
  task automatic drain_writes();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
  endtask

  // Result side: a long hold-off on request, always ready while calm, otherwise random stalls.
  initial begin
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (calm) begin
        out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Compare every write that leaves the block with the oldest expected one.
  always @(posedge clk) begin
    disp_write_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_writes.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected write: expected none, got position %0d segments %02h last %0b",
                 $time, out_ch.position, out_ch.segments, out_ch.last);
      end else begin
        want = pending_writes.pop_front();
        if (out_ch.position !== want.position) begin
          mismatch_count++;
          $display("%0t: position: expected %0d, got %0d",
                   $time, want.position, out_ch.position);
        end
        if (out_ch.segments !== want.segments) begin
          mismatch_count++;
          $display("%0t: segments: expected %02h, got %02h",
                   $time, want.segments, out_ch.segments);
        end
        if (out_ch.last !== want.last) begin
          mismatch_count++;
          $display("%0t: last: expected %0b, got %0b", $time, want.last, out_ch.last);
        end
      end
    end
  end

  // Stimulus: reset, directed rows, then random numbers.
  initial begin
    number_t num;
    int      n;

    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.value       = '0;
    in_ch.signed_mode = 1'b0;
    in_ch.radix_code  = RADIX_ZERO;
    in_ch.dot_mask    = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      offer_number(directed_rows[i].num);
      if (directed_rows[i].write_count == 0) predict_writes(directed_rows[i].num);
      else queue_written_out(directed_rows[i]);
    end

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      // Hold the result side off while numbers keep coming, so the block
      // backs up and stops taking input.
      if (n == 100) begin
        calm = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      // Let everything drain before going on.
      if (n == 200) drain_writes();
      num = random_number();
      offer_number(num);
      predict_writes(num);
    end

    drain_writes();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(LIMIT_NS);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> files.f
hdl/rsf_pkg.sv
hdl/rsf_channels.sv
hdl/rsf_digit_cell.sv
hdl/rsf_converter.sv
hdl/rsf_emitter.sv
hdl/radix_seven_segment_formatter.sv
sim/testbench.sv
